// ===== rtl/core/x10rf_pkg.sv =====
// shared types and constants for the x10 rf pulse decoder
// no dependencies; imported by every module of the block
`default_nettype none

package x10rf_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [7:0]  TIME_SCALE_RST     = 8'd1;
    localparam logic [15:0] SYNC_THRESHOLD_RST = 16'd3000;
    localparam logic [15:0] BIT_THRESHOLD_RST  = 16'd600;

    localparam logic [2:0] CMD_OFF     = 3'd0;
    localparam logic [2:0] CMD_ON      = 3'd1;
    localparam logic [2:0] CMD_BRIGHT  = 3'd2;
    localparam logic [2:0] CMD_DIM     = 3'd3;
    localparam logic [2:0] CMD_ALL_OFF = 3'd4;
    localparam logic [2:0] CMD_ALL_ON  = 3'd5;

    localparam logic [4:0] UNIT_MAX = 5'd16;

    typedef struct packed {
        logic [15:0] pulse_width;
        logic        last_pulse;
    } pulse_t;

    typedef struct packed {
        logic       accepted;
        logic [3:0] house_code;
        logic [4:0] unit_number;
        logic [2:0] command_code;
    } result_t;

    typedef struct packed {
        logic [7:0]  time_scale;
        logic [15:0] sync_threshold;
        logic [15:0] bit_threshold;
    } cfg_t;

    // train state as seen after the current item has been folded in
    typedef struct packed {
        logic [6:0]  count;
        logic        first_long;
        logic        second_long;
        logic [31:0] bits;
    } train_t;

endpackage

`default_nettype wire

// ===== rtl/core/x10rf_regs.sv =====
// apb configuration registers: time scale, sync and bit thresholds
// depends on x10rf_pkg
`default_nettype none

module x10rf_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [x10rf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [x10rf_pkg::DATA_W-1:0] pwdata,
    output logic      [x10rf_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output x10rf_pkg::cfg_t                 cfg
);
    import x10rf_pkg::*;

    typedef enum logic [1:0] {
        REG_TIME_SCALE = 2'd0,
        REG_SYNC_THR   = 2'd1,
        REG_BIT_THR    = 2'd2,
        REG_NONE       = 2'd3
    } reg_idx_t;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_scale     <= TIME_SCALE_RST;
            cfg_reg.sync_threshold <= SYNC_THRESHOLD_RST;
            cfg_reg.bit_threshold  <= BIT_THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TIME_SCALE: cfg_reg.time_scale     <= pwdata[7:0];
                REG_SYNC_THR:   cfg_reg.sync_threshold <= pwdata[15:0];
                REG_BIT_THR:    cfg_reg.bit_threshold  <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TIME_SCALE: prdata = {24'd0, cfg_reg.time_scale};
            REG_SYNC_THR:   prdata = {16'd0, cfg_reg.sync_threshold};
            REG_BIT_THR:    prdata = {16'd0, cfg_reg.bit_threshold};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/x10rf_train.sv =====
// train tracker: scales each duration, counts pulses, keeps sync flags
// and the gap bit shift register; depends on x10rf_pkg
`default_nettype none

module x10rf_train (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire x10rf_pkg::cfg_t   cfg,
    input  wire logic              step,
    input  wire x10rf_pkg::pulse_t pulse,
    output x10rf_pkg::train_t      train
);
    import x10rf_pkg::*;

    localparam logic [6:0] COUNT_MAX = 7'd127;

    logic [6:0]  count_reg,  count_next;
    logic        first_reg,  first_next;
    logic        second_reg, second_next;
    logic [32:0] shift_reg,  shift_next;

    logic [23:0] scaled;
    logic        sync_long;
    logic        bit_one;
    logic [6:0]  count_upd;
    logic        first_upd;
    logic        second_upd;
    logic [32:0] shift_upd;

    assign scaled    = {8'd0, pulse.pulse_width} * {16'd0, cfg.time_scale};
    assign sync_long = scaled > {8'd0, cfg.sync_threshold};
    assign bit_one   = scaled > {8'd0, cfg.bit_threshold};

    always_comb
    begin
        count_upd  = (count_reg != COUNT_MAX) ? count_reg + 7'd1 : count_reg;
        first_upd  = (count_upd == 7'd1) ? sync_long : first_reg;
        second_upd = (count_upd == 7'd2) ? sync_long : second_reg;
        shift_upd  = count_upd[0] ? shift_reg : {shift_reg[31:0], bit_one};

        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        shift_next  = shift_reg;
        if (step)
        begin
            if (pulse.last_pulse)
            begin
                count_next  = '0;
                first_next  = 1'b0;
                second_next = 1'b0;
                shift_next  = '0;
            end
            else
            begin
                count_next  = count_upd;
                first_next  = first_upd;
                second_next = second_upd;
                shift_next  = shift_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            first_reg  <= 1'b0;
            second_reg <= 1'b0;
            shift_reg  <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            shift_reg  <= shift_next;
        end
    end

    assign train.count       = count_upd;
    assign train.first_long  = first_upd;
    assign train.second_long = second_upd;
    assign train.bits        = shift_upd[32:1];

endmodule

`default_nettype wire

// ===== rtl/core/x10rf_decode.sv =====
// frame check and x10 field decode of the collected 32 gap bits
// depends on x10rf_pkg
`default_nettype none

module x10rf_decode (
    input  wire x10rf_pkg::train_t train,
    output x10rf_pkg::result_t     result
);
    import x10rf_pkg::*;

    localparam logic [6:0] SHORT_TRAIN = 7'd66;
    localparam logic [6:0] LONG_TRAIN  = 7'd68;
    localparam logic [7:0] B2_UNIT_MASK = 8'h87;
    localparam logic [7:0] B2_OFF_BIT   = 8'h20;
    localparam logic [7:0] B2_BRIGHT    = 8'h88;
    localparam logic [7:0] B2_DIM       = 8'h98;
    localparam logic [7:0] B2_ALL_OFF   = 8'h80;
    localparam logic [7:0] B2_ALL_ON    = 8'h90;
    localparam logic [3:0] UPPER_BANK   = 4'h4;

    function automatic logic [3:0] house_of(input logic [3:0] nib);
        logic [3:0] h;
        case (nib)
            4'h0: h = 4'd12;
            4'h1: h = 4'd13;
            4'h2: h = 4'd14;
            4'h3: h = 4'd15;
            4'h4: h = 4'd2;
            4'h5: h = 4'd3;
            4'h6: h = 4'd0;
            4'h7: h = 4'd1;
            4'h8: h = 4'd4;
            4'h9: h = 4'd5;
            4'ha: h = 4'd6;
            4'hb: h = 4'd7;
            4'hc: h = 4'd10;
            4'hd: h = 4'd11;
            4'he: h = 4'd8;
            4'hf: h = 4'd9;
            default: h = 4'd0;
        endcase
        return h;
    endfunction

    logic       frame_ok;
    logic [7:0] b0, b1, b2, b3;
    logic [4:0] unit;
    logic [2:0] cmd;

    assign frame_ok = (train.count == SHORT_TRAIN) ||
                      (train.count == LONG_TRAIN && train.first_long && train.second_long);
    assign b0 = train.bits[31:24];
    assign b1 = ~train.bits[23:16];
    assign b2 = train.bits[15:8];
    assign b3 = ~train.bits[7:0];

    always_comb
    begin
        unit = '0;
        cmd  = CMD_OFF;
        if ((b2 & B2_UNIT_MASK) == 8'h00)
        begin
            unit = 5'd1 + {4'd0, b2[4]} + {3'd0, b2[3], 1'b0} + {2'd0, b2[6], 2'b00};
            cmd  = ((b2 & B2_OFF_BIT) != 8'h00) ? CMD_OFF : CMD_ON;
        end
        else if (b2 == B2_BRIGHT)
            cmd = CMD_BRIGHT;
        else if (b2 == B2_DIM)
            cmd = CMD_DIM;
        else if (b2 == B2_ALL_OFF)
            cmd = CMD_ALL_OFF;
        else if (b2 == B2_ALL_ON)
            cmd = CMD_ALL_ON;
        // upper bank of units
        if (b0[3:0] == UPPER_BANK && (cmd == CMD_OFF || cmd == CMD_ON))
            unit = unit + 5'd8;

        result = '0;
        if (frame_ok && b0 == b1 && b2 == b3)
        begin
            result.accepted     = 1'b1;
            result.house_code   = house_of(b0[7:4]);
            result.unit_number  = unit;
            result.command_code = cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/x10_rf_pulse_decoder.sv =====
// x10 rf pulse decoder top level: input item register, train tracker,
// decoder and result register; no stall from config; result path is
// input item register, then result register; a full result register
// stalls a last item, else one item per cycle, set by the input stage
// reset: rst_n async low, clears train state, valid flags and config regs
`default_nettype none

module x10_rf_pulse_decoder (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pulse_valid,
    output logic                              pulse_ready,
    input  wire x10rf_pkg::pulse_t            pulse,
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output x10rf_pkg::result_t                result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [x10rf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [x10rf_pkg::DATA_W-1:0] pwdata,
    output logic      [x10rf_pkg::DATA_W-1:0] prdata,
    output logic                              pready
);
    import x10rf_pkg::*;

    cfg_t    cfg;
    train_t  train;
    result_t decoded;

    pulse_t  pulse_reg;
    logic    pulse_vld_reg;
    result_t result_reg;
    logic    result_vld_reg;
    logic    advance;
    logic    out_free;

    x10rf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    x10rf_train u_train (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (advance),
        .pulse (pulse_reg),
        .train (train)
    );

    x10rf_decode u_decode (
        .train  (train),
        .result (decoded)
    );

    assign out_free    = !result_vld_reg || result_ready;
    assign advance     = pulse_vld_reg && (!pulse_reg.last_pulse || out_free);
    assign pulse_ready = !pulse_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pulse_vld_reg <= 1'b0;
        else if (pulse_ready)
            pulse_vld_reg <= pulse_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pulse_valid && pulse_ready)
            pulse_reg <= pulse;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_vld_reg <= 1'b0;
        else if (advance && pulse_reg.last_pulse)
            result_vld_reg <= 1'b1;
        else if (result_ready)
            result_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && pulse_reg.last_pulse)
            result_reg <= decoded;
    end

    assign result_valid = result_vld_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && pulse_reg.last_pulse |=> result_vld_reg)
        else $error("last pulse item did not produce a result");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_vld_reg && !result_reg.accepted |->
            result_reg.house_code == 4'd0 && result_reg.unit_number == 5'd0 &&
            result_reg.command_code == CMD_OFF)
        else $error("rejected train carries nonzero fields");

    a_accept_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_vld_reg && result_reg.accepted |->
            result_reg.unit_number <= UNIT_MAX && result_reg.command_code <= CMD_ALL_ON)
        else $error("decoded unit or command out of range");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// testbench for x10_rf_pulse_decoder: drives whole rf pulse trains and apb register writes,
// checks each result against a table value or an in-bench decoder model of the train
// depends on x10rf_pkg and the x10_rf_pulse_decoder rtl only
`timescale 1ns / 100ps

module testbench;
    import x10rf_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_PCT = 21;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS = 40;
    localparam int PHASES = 7;
    localparam int NUM_REGS = 3;

    localparam logic [7:0] SHORT_LEN = 8'd66;
    localparam logic [7:0] LONG_LEN = 8'd68;
    localparam logic [6:0] COUNT_MAX = 7'd127;

    localparam logic [ADDR_W-1:0] ADDR_TIME_SCALE = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_SYNC_THR = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_BIT_THR = 4'd8;
    localparam logic [ADDR_W-1:0] ADDR_SPARE = 4'd12;
    localparam logic [ADDR_W-1:0] REG_ADDR [NUM_REGS] = '{ADDR_TIME_SCALE, ADDR_SYNC_THR,
                                                         ADDR_BIT_THR};

    localparam logic [7:0] UNIT_MASK = 8'h87;
    localparam logic [7:0] B2_BRIGHT = 8'h88;
    localparam logic [7:0] B2_DIM = 8'h98;
    localparam logic [7:0] B2_ALL_OFF = 8'h80;
    localparam logic [7:0] B2_ALL_ON = 8'h90;
    localparam logic [3:0] BANK_NIBBLE = 4'h4;
    localparam logic [7:0] GROUP_CODES [4] = '{B2_BRIGHT, B2_DIM, B2_ALL_OFF, B2_ALL_ON};

    localparam logic [3:0] HOUSE_OF_NIBBLE [16] = '{
        4'd12, 4'd13, 4'd14, 4'd15, 4'd2, 4'd3, 4'd0, 4'd1,
        4'd4, 4'd5, 4'd6, 4'd7, 4'd10, 4'd11, 4'd8, 4'd9
    };

    typedef struct packed {
        logic [7:0]  len;
        logic [1:0]  sync_long;
        logic [31:0] word;
        logic        extreme;
        logic        typed;
        result_t     want;
    } train_row_t;

    localparam result_t REJECT = {1'b0, 4'd0, 5'd0, CMD_OFF};

    localparam train_row_t DIRECTED [19] = '{
        {8'd66, 2'b00, 32'h609F00FF, 1'b0, 1'b1, {1'b1, 4'd0, 5'd1, CMD_ON}},
        {8'd68, 2'b11, 32'h649B20DF, 1'b0, 1'b1, {1'b1, 4'd0, 5'd9, CMD_OFF}},
        {8'd68, 2'b01, 32'h649B20DF, 1'b0, 1'b1, REJECT},
        {8'd68, 2'b10, 32'h649B20DF, 1'b0, 1'b1, REJECT},
        {8'd66, 2'b00, 32'h906F8877, 1'b0, 1'b1, {1'b1, 4'd5, 5'd0, CMD_BRIGHT}},
        {8'd66, 2'b00, 32'h04FB9867, 1'b0, 1'b1, {1'b1, 4'd12, 5'd0, CMD_DIM}},
        {8'd68, 2'b11, 32'hF00F807F, 1'b0, 1'b1, {1'b1, 4'd9, 5'd0, CMD_ALL_OFF}},
        {8'd66, 2'b00, 32'h30CF906F, 1'b0, 1'b1, {1'b1, 4'd15, 5'd0, CMD_ALL_ON}},
        {8'd66, 2'b00, 32'h609F01FE, 1'b0, 1'b1, {1'b1, 4'd0, 5'd0, CMD_OFF}},
        {8'd66, 2'b00, 32'h649BFF00, 1'b0, 1'b1, {1'b1, 4'd0, 5'd8, CMD_OFF}},
        {8'd66, 2'b00, 32'h649B58A7, 1'b0, 1'b1, {1'b1, 4'd0, 5'd16, CMD_ON}},
        {8'd66, 2'b00, 32'h609E00FF, 1'b0, 1'b1, REJECT},
        {8'd66, 2'b00, 32'h609F00FE, 1'b0, 1'b1, REJECT},
        {8'd65, 2'b00, 32'h609F00FF, 1'b0, 1'b1, REJECT},
        {8'd1, 2'b00, 32'h609F00FF, 1'b0, 1'b1, REJECT},
        {8'd130, 2'b11, 32'h609F00FF, 1'b0, 1'b1, REJECT},
        {8'd66, 2'b01, 32'hFF0000FF, 1'b1, 1'b1, {1'b1, 4'd9, 5'd1, CMD_ON}},
        {8'd68, 2'b11, 32'h10EFA05F, 1'b0, 1'b0, REJECT},
        {8'd66, 2'b00, 32'h2BD448B7, 1'b0, 1'b0, REJECT}
    };

    localparam cfg_t PHASE_CFG [PHASES-2] = '{
        {8'd255, 16'hFFFF, 16'hFFFF},
        {8'd1, 16'd0, 16'd0},
        {8'd0, 16'd0, 16'd0},
        {8'd1, 16'hFFFF, 16'hFFFF},
        {8'd200, 16'd50000, 16'd12000}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic pulse_valid;
    logic pulse_ready;
    pulse_t pulse_item;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result_item;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    logic [7:0] scale_reg;
    logic [15:0] sync_thr;
    logic [15:0] bit_thr;
    logic [6:0] seen_count;
    logic first_long;
    logic second_long;
    logic [32:0] gap_bits;

    result_t expected_decodes [$];
    pulse_t train_q [$];
    int mismatch_count = 0;
    int cycle_count = 0;
    logic steady = 1'b0;

    x10_rf_pulse_decoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .pulse_valid(pulse_valid),
        .pulse_ready(pulse_ready),
        .pulse(pulse_item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result_item),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    function automatic void clear_train();
        seen_count = 7'd0;
        first_long = 1'b0;
        second_long = 1'b0;
        gap_bits = 33'd0;
    endfunction

    // folds one pulse into the train; returns 1 when the pulse closes the train
    function automatic logic track_pulse(input pulse_t p, output result_t r);
        logic [23:0] scaled;
        logic [31:0] bits;
        logic [7:0] b0, b1, b2, b3;
        logic valid_train;
        scaled = 24'(p.pulse_width) * 24'(scale_reg);
        if (seen_count != COUNT_MAX)
            seen_count = seen_count + 7'd1;
        if (seen_count == 7'd1)
            first_long = scaled > 24'(sync_thr);
        if (seen_count == 7'd2)
            second_long = scaled > 24'(sync_thr);
        if (!seen_count[0])
            gap_bits = {gap_bits[31:0], scaled > 24'(bit_thr)};
        r = '0;
        if (!p.last_pulse)
            return 1'b0;
        valid_train = (seen_count == SHORT_LEN[6:0])
                      || (seen_count == LONG_LEN[6:0] && first_long && second_long);
        bits = gap_bits[32:1];
        b0 = bits[31:24];
        b1 = ~bits[23:16];
        b2 = bits[15:8];
        b3 = ~bits[7:0];
        if (valid_train && b0 == b1 && b2 == b3)
        begin
            r.accepted = 1'b1;
            r.house_code = HOUSE_OF_NIBBLE[b0[7:4]];
            if ((b2 & UNIT_MASK) == 8'h00)
            begin
                r.unit_number = 5'd1 + {2'b00, b2[6], b2[3], b2[4]};
                r.command_code = b2[5] ? CMD_OFF : CMD_ON;
            end
            else if (b2 == B2_BRIGHT)
                r.command_code = CMD_BRIGHT;
            else if (b2 == B2_DIM)
                r.command_code = CMD_DIM;
            else if (b2 == B2_ALL_OFF)
                r.command_code = CMD_ALL_OFF;
            else if (b2 == B2_ALL_ON)
                r.command_code = CMD_ALL_ON;
            if (b0[3:0] == BANK_NIBBLE && r.command_code < CMD_BRIGHT)
                r.unit_number = r.unit_number + 5'd8;
        end
        clear_train();
        return 1'b1;
    endfunction

    // width whose scaled value is above or at/below thr, often closest to it; any at zero scale
    function automatic logic [15:0] width_for(input logic [15:0] thr, input logic above);
        int unsigned lo;
        if (scale_reg == 8'd0)
            return 16'($urandom);
        lo = 32'(thr) / 32'(scale_reg) + 1;
        if (above)
        begin
            if (lo > 32'hFFFF)
                return 16'hFFFF;
            return ($urandom_range(0, 3) == 0) ? 16'(lo) : 16'($urandom_range(lo, 32'hFFFF));
        end
        return ($urandom_range(0, 3) == 0) ? 16'(lo - 1) : 16'($urandom_range(0, lo - 1));
    endfunction

    function automatic logic [31:0] random_word();
        logic [7:0] b0, b2;
        b0 = 8'($urandom);
        if ($urandom_range(0, 3) == 0)
            b0[3:0] = BANK_NIBBLE;
        case ($urandom_range(0, 3))
            0, 1: b2 = 8'($urandom) & ~UNIT_MASK;
            2: b2 = GROUP_CODES[$urandom_range(0, 3)];
            default: b2 = 8'($urandom);
        endcase
        return {b0, ~b0, b2, ~b2};
    endfunction

    task automatic build_train(input logic [7:0] len, input logic [1:0] sync_long,
                               input logic [31:0] word, input logic extreme);
        pulse_t p;
        int data_idx;
        logic bit_val;
        train_q.delete();
        for (int k = 1; k <= len; k++)
        begin
            p.last_pulse = (k == len);
            data_idx = k / 2 - ((len == LONG_LEN) ? 2 : 1);
            if (k == 1 || (k == 2 && len == LONG_LEN))
                p.pulse_width = extreme ? 16'hFFFF : width_for(sync_thr, sync_long[k-1]);
            else if (k % 2 == 1)
                p.pulse_width = extreme ? 16'hFFFF : 16'($urandom);
            else
            begin
                bit_val = (data_idx >= 0 && data_idx < 32) ? word[31 - data_idx]
                                                          : 1'($urandom);
                if (extreme)
                    p.pulse_width = bit_val ? 16'hFFFF : 16'h0000;
                else
                    p.pulse_width = width_for(bit_thr, bit_val);
            end
            train_q.push_back(p);
        end
    endtask

    task automatic send_pulse(input pulse_t p, input logic typed, input result_t want);
        result_t decoded;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            pulse_valid <= 1'b0;
            @(posedge clk);
        end
        pulse_valid <= 1'b1;
        pulse_item <= p;
        do
            @(posedge clk);
        while (!pulse_ready);
        if (track_pulse(p, decoded))
            expected_decodes.push_back(typed ? want : decoded);
    endtask

    task automatic send_train(input logic typed, input result_t want);
        foreach (train_q[k])
            send_pulse(train_q[k], typed, want);
    endtask

    task automatic random_train();
        int unsigned pick;
        int unsigned flip;
        logic [7:0] len;
        logic [1:0] sync_long;
        logic [31:0] word;
        pick = $urandom_range(0, 99);
        word = random_word();
        sync_long = 2'b11;
        if (pick < 40)
            len = SHORT_LEN;
        else if (pick < 72)
            len = LONG_LEN;
        else if (pick < 80)
        begin
            len = LONG_LEN;
            sync_long = 2'($urandom);
        end
        else if (pick < 88)
        begin
            len = ($urandom_range(0, 1) == 1) ? LONG_LEN : SHORT_LEN;
            flip = $urandom_range(0, 31);
            word[flip] = ~word[flip];
        end
        else if (pick < 95)
            len = 8'($urandom_range(1, 12));
        else
            len = 8'($urandom_range(13, 140));
        build_train(len, sync_long, word, 1'b0);
        send_train(1'b0, REJECT);
    endtask

    task automatic settle();
        pulse_valid <= 1'b0;
        while (expected_decodes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(input cfg_t c);
        logic [DATA_W-1:0] vals [NUM_REGS];
        logic [DATA_W-1:0] rd;
        vals = '{32'(c.time_scale), 32'(c.sync_threshold), 32'(c.bit_threshold)};
        for (int i = 0; i < NUM_REGS; i++)
            apb_access(1'b1, REG_ADDR[i], vals[i], rd);
        scale_reg = c.time_scale;
        sync_thr = c.sync_threshold;
        bit_thr = c.bit_threshold;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_access(1'b0, REG_ADDR[i], 32'd0, rd);
            if (rd !== vals[i])
                report_mismatch("register readback", rd, vals[i]);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_decodes.size() == 0)
                report_mismatch("unexpected result", 32'(result_item), 32'd0);
            else
            begin
                want = expected_decodes.pop_front();
                if (result_item.accepted !== want.accepted)
                    report_mismatch("accepted", 32'(result_item.accepted), 32'(want.accepted));
                if (result_item.house_code !== want.house_code)
                    report_mismatch("house_code", 32'(result_item.house_code),
                                    32'(want.house_code));
                if (result_item.unit_number !== want.unit_number)
                    report_mismatch("unit_number", 32'(result_item.unit_number),
                                    32'(want.unit_number));
                if (result_item.command_code !== want.command_code)
                    report_mismatch("command_code", 32'(result_item.command_code),
                                    32'(want.command_code));
            end
        end
        result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial
    begin
        cfg_t cfg;
        logic [DATA_W-1:0] rd;
        rst_n = 1'b0;
        pulse_valid = 1'b0;
        pulse_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        scale_reg = TIME_SCALE_RST;
        sync_thr = SYNC_THRESHOLD_RST;
        bit_thr = BIT_THRESHOLD_RST;
        clear_train();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unmapped register, must leave the config alone
        apb_access(1'b1, ADDR_SPARE, $urandom, rd);

        foreach (DIRECTED[i])
        begin
            build_train(DIRECTED[i].len, DIRECTED[i].sync_long, DIRECTED[i].word,
                        DIRECTED[i].extreme);
            send_train(DIRECTED[i].typed, DIRECTED[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                settle();
                if (ph < PHASES - 1)
                    cfg = PHASE_CFG[ph - 1];
                else
                    cfg = {8'($urandom_range(1, 255)), 16'($urandom), 16'($urandom)};
                program_regs(cfg);
            end
            steady = (ph == 2);
            repeat ((ph == 0) ? 0 : ((ph == 2) ? 2 : 1)) random_train();
        end

        settle();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
